/* rtl/core/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the shortest-path relaxation engine.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int NODE_BITS = 6;
    localparam int MAX_NODES = 64;
    localparam int EDGE_BITS = 2 * NODE_BITS;
    localparam int COST_BITS = 16;
    localparam int DIST_BITS = 29;
    localparam int OUT_COST_BITS = 28;
    localparam int CNT_BITS = 7;
    localparam logic [DIST_BITS-1:0] SUM_LIMIT = {{(DIST_BITS-1){1'b1}}, 1'b0};

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE     = 2'd1;
    localparam logic [1:0] REG_DEST       = 2'd2;

    typedef enum logic [9:0] {
        ST_LOAD    = 10'b0000000001,
        ST_INIT    = 10'b0000000010,
        ST_SREAD   = 10'b0000000100,
        ST_SDIST   = 10'b0000001000,
        ST_SCMP    = 10'b0000010000,
        ST_WREAD   = 10'b0000100000,
        ST_WSTORE  = 10'b0001000000,
        ST_EMIT    = 10'b0010000000,
        ST_CLEAR   = 10'b0100000000,
        ST_BOOT    = 10'b1000000000
    } state_t;

endpackage

/* rtl/core/shortest_path_relaxation.sv */
// ----------------------------------------------------------------------------
// shortest_path_relaxation
// Bellman-Ford engine over an edge-cost memory with in-place sweeps.
// ----------------------------------------------------------------------------
// Usage: edges arrive on the s_axis channel (tdata = from, to, cost; tlast
// marks the final edge). Each edge with both nodes below the node count
// is written to the edge memory. After the last edge the engine
// initializes 64 distances, then sweeps every edge slot of the active
// node_count x node_count square, each slot through edge read, distance
// read, compare and write back, repeating until a sweep changes nothing.
// The path is then walked backward through the parent memory and emitted
// source first on m_axis, one transfer per node, tlast on the final one.
// m_axis tready low simply holds the output register. Then a clearing
// pass over every edge slot resets the edge-present memory; the same
// pass also runs after reset, and no edge is taken during it.
// Configuration is written through cfg_we/cfg_addr/cfg_data while idle.
// ----------------------------------------------------------------------------
module shortest_path_relaxation
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // from_node[5:0], to_node[11:6], edge_cost[27:12]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // path_node[5:0], path_found[6], total_cost[34:7]
    output logic        m_axis_tlast
);

    logic [CNT_BITS-1:0]  node_count_reg;
    logic [NODE_BITS-1:0] source_reg, dest_reg;
    state_t               state_reg;

    logic                 pres_mem [MAX_NODES*MAX_NODES];
    logic [COST_BITS-1:0] cost_mem [MAX_NODES*MAX_NODES];
    logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
    logic [NODE_BITS-1:0] par_mem  [MAX_NODES];
    logic [NODE_BITS-1:0] stk_mem  [MAX_NODES];

    logic [CNT_BITS-1:0]  n_act;
    logic [EDGE_BITS:0]   clr_reg;
    logic [DIST_BITS-1:0] sum_reg, inf_reg;
    logic [NODE_BITS-1:0] i_reg, j_reg;
    logic                 changed_reg;
    logic                 pres_q;
    logic [COST_BITS-1:0] cost_q;
    logic [DIST_BITS-1:0] dist_q;
    logic [DIST_BITS:0]   cand_reg;
    logic [NODE_BITS-1:0] v_reg;
    logic [CNT_BITS-1:0]  depth_reg, k_reg;
    logic                 found_reg;
    logic [OUT_COST_BITS-1:0] total_reg;
    logic [NODE_BITS-1:0] par_q, stk_q;
    logic                 emit_rd_reg;

    logic [NODE_BITS-1:0] in_from, in_to;
    logic [COST_BITS-1:0] in_cost;
    logic                 in_ok, in_xfer;
    logic [DIST_BITS:0]   sum_add;
    logic                 in_range;

    assign in_from = s_axis_tdata[5:0];
    assign in_to   = s_axis_tdata[11:6];
    assign in_cost = s_axis_tdata[27:12];

    always_comb
    begin
        if (node_count_reg == '0)
            n_act = CNT_BITS'(1);
        else if (node_count_reg > CNT_BITS'(MAX_NODES))
            n_act = CNT_BITS'(MAX_NODES);
        else
            n_act = node_count_reg;
    end

    assign in_ok    = ({1'b0, in_from} < n_act) && ({1'b0, in_to} < n_act);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign sum_add  = {1'b0, sum_reg} + (DIST_BITS+1)'(in_cost);
    assign in_range = ({1'b0, source_reg} < n_act) && ({1'b0, dest_reg} < n_act);
    assign s_axis_tready = (state_reg == ST_LOAD);

    // memory ports
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BOOT || state_reg == ST_CLEAR)
            pres_mem[clr_reg[EDGE_BITS-1:0]] <= 1'b0;
        else if (in_xfer && in_ok)
            pres_mem[{in_from, in_to}] <= 1'b1;
        pres_q <= pres_mem[{i_reg, j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_ok)
            cost_mem[{in_from, in_to}] <= in_cost;
        cost_q <= cost_mem[{i_reg, j_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INIT)
            dist_mem[clr_reg[NODE_BITS-1:0]] <=
                (clr_reg[NODE_BITS-1:0] == source_reg) ? '0 : inf_reg;
        else if (state_reg == ST_SCMP && pres_q && {1'b0, dist_q} > cand_reg)
            dist_mem[j_reg] <= cand_reg[DIST_BITS-1:0];
        // SREAD reads dist[i], SDIST reads dist[j]
        dist_q <= dist_mem[(state_reg == ST_SREAD) ? i_reg : j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_INIT)
            par_mem[clr_reg[NODE_BITS-1:0]] <= '0;
        else if (state_reg == ST_SCMP && pres_q && {1'b0, dist_q} > cand_reg)
            par_mem[j_reg] <= i_reg;
        par_q <= par_mem[v_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WSTORE)
            stk_mem[depth_reg[NODE_BITS-1:0]] <= v_reg;
        stk_q <= stk_mem[k_reg[NODE_BITS-1:0]];
    end

    // cfg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_BITS'(MAX_NODES);
            source_reg     <= '0;
            dest_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_NODE_COUNT: node_count_reg <= cfg_data;
                REG_SOURCE:     source_reg     <= cfg_data[NODE_BITS-1:0];
                REG_DEST:       dest_reg       <= cfg_data[NODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BOOT;
            clr_reg       <= '0;
            sum_reg       <= '0;
            inf_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            changed_reg   <= 1'b0;
            cand_reg      <= '0;
            v_reg         <= '0;
            depth_reg     <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            total_reg     <= '0;
            emit_rd_reg   <= 1'b0;
            m_axis_tvalid <= 1'b0;
            m_axis_tdata  <= '0;
            m_axis_tlast  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_BOOT, ST_CLEAR:
                begin
                    if (clr_reg == (EDGE_BITS+1)'(MAX_NODES*MAX_NODES-1))
                    begin
                        clr_reg   <= '0;
                        state_reg <= ST_LOAD;
                    end
                    else
                        clr_reg <= clr_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        logic [DIST_BITS-1:0] s;
                        s = sum_reg;
                        if (in_ok)
                            s = (sum_add > (DIST_BITS+1)'(SUM_LIMIT)) ? SUM_LIMIT
                                : sum_add[DIST_BITS-1:0];
                        sum_reg <= s;
                        if (s_axis_tlast)
                        begin
                            inf_reg   <= s + 1'b1;
                            clr_reg   <= '0;
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT:
                begin
                    if (clr_reg[NODE_BITS-1:0] == NODE_BITS'(MAX_NODES-1))
                    begin
                        clr_reg     <= '0;
                        i_reg       <= '0;
                        j_reg       <= '0;
                        changed_reg <= 1'b0;
                        if (in_range)
                            state_reg <= ST_SREAD;
                        else
                        begin
                            found_reg <= 1'b0;
                            state_reg <= ST_WREAD;
                        end
                    end
                    else
                        clr_reg <= clr_reg + 1'b1;
                end
                ST_SREAD:
                    state_reg <= ST_SDIST;
                ST_SDIST:
                begin
                    cand_reg   <= {1'b0, dist_q} + (DIST_BITS+1)'(cost_q);
                    state_reg  <= ST_SCMP;
                end
                ST_SCMP:
                begin
                    logic upd;
                    upd = pres_q && ({1'b0, dist_q} > cand_reg);
                    if (upd)
                        changed_reg <= 1'b1;
                    state_reg <= ST_SREAD;
                    if ({1'b0, j_reg} == n_act - 1'b1)
                    begin
                        j_reg <= '0;
                        if ({1'b0, i_reg} == n_act - 1'b1)
                        begin
                            i_reg <= '0;
                            changed_reg <= 1'b0;
                            if (!(changed_reg || upd))
                            begin
                                v_reg     <= dest_reg;
                                depth_reg <= '0;
                                state_reg <= ST_WREAD;
                            end
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                ST_WREAD:
                begin
                    if (!in_range)
                    begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata  <= '0;
                        m_axis_tlast  <= 1'b1;
                        state_reg     <= ST_EMIT;
                        depth_reg     <= '0;
                    end
                    else if (source_reg == dest_reg)
                    begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tdata  <= {5'd0, 28'd0, 1'b1, source_reg};
                        m_axis_tlast  <= 1'b1;
                        state_reg     <= ST_EMIT;
                        depth_reg     <= '0;
                    end
                    else
                    begin
                        // point the distance read at the destination
                        j_reg     <= dest_reg;
                        state_reg <= ST_WSTORE;
                    end
                end
                ST_WSTORE:
                begin
                    // dest distance is registered into dist_q before it is checked against inf
                    if (depth_reg == '0 && !emit_rd_reg)
                    begin
                        emit_rd_reg <= 1'b1;
                        j_reg       <= dest_reg;
                    end
                    else if (depth_reg == '0 && emit_rd_reg && !found_reg)
                    begin
                        if (dist_q >= inf_reg)
                        begin
                            emit_rd_reg   <= 1'b0;
                            m_axis_tvalid <= 1'b1;
                            m_axis_tdata  <= '0;
                            m_axis_tlast  <= 1'b1;
                            state_reg     <= ST_EMIT;
                        end
                        else
                        begin
                            found_reg <= 1'b1;
                            total_reg <= dist_q[OUT_COST_BITS-1:0];
                        end
                    end
                    else
                    begin
                        // store v, advance to parent (par_q read last cycle)
                        if (emit_rd_reg)
                        begin
                            emit_rd_reg <= 1'b0;
                            depth_reg   <= depth_reg + 1'b1;
                            if (v_reg == source_reg || depth_reg + 1'b1 >= n_act)
                            begin
                                k_reg     <= depth_reg;
                                state_reg <= ST_EMIT;
                            end
                        end
                        else
                        begin
                            v_reg       <= par_q;
                            emit_rd_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!found_reg || depth_reg == '0)
                    begin
                        if (m_axis_tready)
                        begin
                            m_axis_tvalid <= 1'b0;
                            found_reg     <= 1'b0;
                            sum_reg       <= '0;
                            clr_reg       <= '0;
                            state_reg     <= ST_CLEAR;
                        end
                    end
                    else if (!m_axis_tvalid || m_axis_tready)
                    begin
                        if (m_axis_tvalid && m_axis_tlast)
                        begin
                            m_axis_tvalid <= 1'b0;
                            found_reg     <= 1'b0;
                            sum_reg       <= '0;
                            clr_reg       <= '0;
                            state_reg     <= ST_CLEAR;
                        end
                        else if (emit_rd_reg)
                        begin
                            emit_rd_reg   <= 1'b0;
                            m_axis_tvalid <= 1'b1;
                            m_axis_tdata  <= {5'd0, total_reg, 1'b1, stk_q};
                            m_axis_tlast  <= (k_reg == '0);
                            k_reg         <= k_reg - 1'b1;
                        end
                        else
                        begin
                            m_axis_tvalid <= 1'b0;
                            emit_rd_reg   <= 1'b1;
                        end
                    end
                end
                default:
                    state_reg <= ST_BOOT;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !s_axis_tready)
        else $error("input ready outside load");
    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (state_reg == ST_EMIT))
        else $error("output valid outside emit");
    a_found_cost: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[6]) |-> m_axis_tlast)
        else $error("no-path result not last");
`endif

endmodule

/* tb/sv/spr_path_checker.sv */
// ----------------------------------------------------------------------------
// spr_path_checker
// Watches the configuration port and both streams of the relaxation engine.
// Keeps its own edge matrix and settings, solves each run when the final
// edge is accepted, and compares every emitted path node with the solution.
// ----------------------------------------------------------------------------
module spr_path_checker
    import spr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          pending,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [NODE_BITS-1:0]     node;
        logic                     found;
        logic [OUT_COST_BITS-1:0] cost;
        logic                     last;
    } path_item_t;

    path_item_t path_q[$];

    logic [CNT_BITS-1:0]  node_count_r;
    logic [NODE_BITS-1:0] source_r;
    logic [NODE_BITS-1:0] dest_r;

    bit                   link_valid [MAX_NODES*MAX_NODES];
    logic [COST_BITS-1:0] link_cost [MAX_NODES*MAX_NODES];
    longint unsigned      node_dist [MAX_NODES];
    int                   parent [MAX_NODES];
    longint unsigned      cost_total;

    assign pending = path_q.size();

    function automatic int nodes_in_use();
        if (node_count_r == 0)
            return 1;
        if (node_count_r > MAX_NODES)
            return MAX_NODES;
        return node_count_r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("ERROR %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic push_item(int node, bit found, longint cost, bit last);
        path_item_t it;
        it.node  = node;
        it.found = found;
        it.cost  = cost;
        it.last  = last;
        path_q.push_back(it);
    endtask

    // Solve the loaded graph and queue the path it yields, then drop the edges.
    task automatic solve_shortest_path();
        int              n;
        longint unsigned inf;
        longint unsigned cand;
        bit              changed;
        bit              ok;
        int              trail [$];
        int              v;
        n   = nodes_in_use();
        inf = cost_total + 1;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            node_dist[i] = inf;
            parent[i]    = 0;
        end
        ok = (source_r < n) && (dest_r < n);
        if (ok)
        begin
            node_dist[source_r] = 0;
            changed = 1;
            while (changed)
            begin
                changed = 0;
                for (int i = 0; i < n; i++)
                    for (int j = 0; j < n; j++)
                        if (link_valid[i*MAX_NODES+j])
                        begin
                            cand = node_dist[i] + link_cost[i*MAX_NODES+j];
                            if (node_dist[j] > cand)
                            begin
                                node_dist[j] = cand;
                                parent[j]    = i;
                                changed      = 1;
                            end
                        end
            end
        end
        if (ok && source_r == dest_r)
            push_item(source_r, 1, 0, 1);
        else if (!ok || node_dist[dest_r] >= inf)
            push_item(0, 0, 0, 1);
        else
        begin
            v = dest_r;
            trail.push_front(v);
            while (v != source_r && trail.size() < n)
            begin
                v = parent[v];
                trail.push_front(v);
            end
            foreach (trail[k])
                push_item(trail[k], 1, node_dist[dest_r], k == trail.size() - 1);
        end
        for (int i = 0; i < MAX_NODES*MAX_NODES; i++)
            link_valid[i] = 0;
        cost_total = 0;
    endtask

    initial
    begin
        errors       = 0;
        node_count_r = 7'd64;
        source_r     = '0;
        dest_r       = '0;
        cost_total   = 0;
        for (int i = 0; i < MAX_NODES*MAX_NODES; i++)
            link_valid[i] = 0;
    end

    always @(posedge clk)
    begin
        logic [NODE_BITS-1:0] from_n;
        logic [NODE_BITS-1:0] to_n;
        path_item_t           want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_NODE_COUNT: node_count_r = cfg_data;
                    REG_SOURCE:     source_r     = cfg_data[NODE_BITS-1:0];
                    REG_DEST:       dest_r       = cfg_data[NODE_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                from_n = s_axis_tdata[5:0];
                to_n   = s_axis_tdata[11:6];
                if (from_n < nodes_in_use() && to_n < nodes_in_use())
                begin
                    link_valid[from_n*MAX_NODES+to_n] = 1;
                    link_cost[from_n*MAX_NODES+to_n]  = s_axis_tdata[27:12];
                    cost_total += s_axis_tdata[27:12];
                    if (cost_total > SUM_LIMIT)
                        cost_total = SUM_LIMIT;
                end
                if (s_axis_tlast)
                    solve_shortest_path();
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (path_q.size() == 0)
                    report("unexpected path transfer, node", m_axis_tdata[5:0], 0);
                else
                begin
                    want = path_q.pop_front();
                    if (m_axis_tdata[5:0] !== want.node)
                        report("path_node", m_axis_tdata[5:0], want.node);
                    if (m_axis_tdata[6] !== want.found)
                        report("path_found", m_axis_tdata[6], want.found);
                    if (m_axis_tdata[34:7] !== want.cost)
                        report("total_cost", m_axis_tdata[34:7], want.cost);
                    if (m_axis_tlast !== want.last)
                        report("last_in_path", m_axis_tlast, want.last);
                end
            end
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the shortest-path relaxation engine: directed graphs for the
// corner cases, then random graphs under changing settings, with bursty
// edge traffic and a stalling path receiver. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import spr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [6:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // from_node[5:0], to_node[11:6], edge_cost[27:12]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // path_node[5:0], path_found[6], total_cost[34:7]
    logic        m_axis_tlast;
    int          pending;
    int          errors;
    int          burst_left;
    int          edges_sent;
    bit          hold_req;
    bit          hold_done;

    shortest_path_relaxation u_dut (.*);

    spr_path_checker u_chk (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: phases of full rate, random stalls, full stops and one long hold-off.
    initial
    begin
        int mode;
        m_axis_tready <= 1'b0;
        hold_done = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 5);
            repeat ($urandom_range(50, 300))
            begin
                @(posedge clk);
                if (hold_req && !hold_done)
                begin
                    // hold off until a result waits, then keep it waiting
                    m_axis_tready <= 1'b0;
                    while (!m_axis_tvalid)
                        @(posedge clk);
                    repeat (600) @(posedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0, 1:    m_axis_tready <= 1'b1;
                    5:       m_axis_tready <= 1'b0;
                    default: m_axis_tready <= ($urandom_range(0, 9) < 6);
                endcase
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Wait for every path node, then let the clearing pass finish.
    task automatic drain_paths();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4200) @(posedge clk);
    endtask

    task automatic set_graph(int n, int src, int dst);
        write_reg(REG_NODE_COUNT, 7'(n));
        write_reg(REG_SOURCE, 7'(src));
        write_reg(REG_DEST, 7'(dst));
    endtask

    // Offer one edge in bursts with random gaps; hold until transferred.
    task automatic send_edge(int from_n, int to_n, int cost, bit last);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, 16'(cost), 6'(to_n), 6'(from_n)};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        edges_sent++;
        if (last)
        begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
    endtask

    function automatic int pick_node(int n);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, n - 1);
    endfunction

    function automatic int pick_cost();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 15);
            1:       return $urandom_range(0, 65535);
            2:       return ($urandom_range(0, 1) != 0) ? 65535 : 0;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    initial
    begin
        int n;
        int cnt;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        burst_left    = 0;
        edges_sent    = 0;
        hold_req      = 1'b0;
        rst_n         <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4200) @(posedge clk);

        // Reset settings: source equals destination, extreme edge values.
        send_edge(63, 63, 65535, 0);
        send_edge(0, 0, 0, 1);
        drain_paths();

        // Small graph, duplicate overwrite, ignored out-of-range edge.
        set_graph(4, 0, 3);
        send_edge(0, 1, 5, 0);
        send_edge(1, 3, 7, 0);
        send_edge(5, 1, 1, 0);
        send_edge(0, 3, 1, 0);
        send_edge(0, 3, 30, 1);
        drain_paths();

        // No path, final edge out of range.
        send_edge(1, 2, 9, 0);
        send_edge(63, 0, 4, 1);
        drain_paths();

        // Source out of range.
        set_graph(3, 5, 1);
        send_edge(0, 1, 2, 1);
        drain_paths();

        // Node count zero acts as one.
        set_graph(0, 0, 0);
        send_edge(0, 0, 3, 1);
        drain_paths();

        // Node count above the maximum acts as the maximum.
        set_graph(127, 63, 0);
        send_edge(63, 42, 65535, 0);
        send_edge(42, 21, 65535, 0);
        send_edge(21, 0, 65535, 0);
        send_edge(63, 0, 65535, 1);

        // Long hold-off on the receiver: keep offering the next graph meanwhile.
        hold_req = 1'b1;
        send_edge(5, 9, 7, 0);
        send_edge(9, 0, 3, 1);
        drain_paths();

        while (edges_sent < 320)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                n = ($urandom_range(0, 14) == 0) ? 64 : $urandom_range(1, 8);
                if ($urandom_range(0, 19) == 0)
                    n = $urandom_range(0, 127);
                set_graph(n, pick_node((n == 0) ? 1 : (n > 64 ? 64 : n)),
                          pick_node((n == 0) ? 1 : (n > 64 ? 64 : n)));
            end
            n   = u_chk.nodes_in_use();
            cnt = (n > 16) ? $urandom_range(10, 30) : $urandom_range(1, 12);
            for (int k = 0; k < cnt; k++)
                send_edge(pick_node(n), pick_node(n), pick_cost(), k == cnt - 1);
            drain_paths();
        end

        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
